### design/tcpcc_pkg.sv
// Shared types, constants and helpers of the TCP sender congestion control core.
`default_nettype none

package tcpcc_pkg;

   // Field widths
   localparam int SEQ_W      = 32;
   localparam int WIN_W      = 16;
   localparam int LEN_W      = 16;
   localparam int SEG_W      = 16;
   localparam int THR_W      = 3;
   localparam int KIND_W     = 2;
   localparam int RES_W      = 3;
   localparam int TIMER_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Divider geometry: segment size times acked bytes over cwnd
   localparam int DVD_W = SEG_W + SEQ_W;
   localparam int DSR_W = SEQ_W;
   localparam int CNT_W = $clog2(DVD_W);

   // Reset values of the configuration registers and of cwnd
   localparam logic [SEG_W-1:0] SEG_SIZE_RESET   = 16'd1000;
   localparam logic [THR_W-1:0] DUP_THRESH_RESET = 3'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEG_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUP_THRESH = 2'd1;

   // Request kinds
   localparam logic [KIND_W-1:0] REQ_OPEN   = 2'd0;
   localparam logic [KIND_W-1:0] REQ_SENT   = 2'd1;
   localparam logic [KIND_W-1:0] REQ_SYNACK = 2'd2;
   localparam logic [KIND_W-1:0] REQ_ACK    = 2'd3;

   // Result kinds
   localparam logic [RES_W-1:0] RES_REJECT = 3'd0;
   localparam logic [RES_W-1:0] RES_DUP    = 3'd1;
   localparam logic [RES_W-1:0] RES_FRTX   = 3'd2;
   localparam logic [RES_W-1:0] RES_NEW    = 3'd3;
   localparam logic [RES_W-1:0] RES_EST    = 3'd4;
   localparam logic [RES_W-1:0] RES_BOOK   = 3'd5;

   // Retransmit timer actions
   localparam logic [TIMER_W-1:0] TMR_KEEP    = 2'd0;
   localparam logic [TIMER_W-1:0] TMR_CLEAR   = 2'd1;
   localparam logic [TIMER_W-1:0] TMR_RESTART = 2'd2;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // a <= b in modulo 2^32 sequence space
   function automatic logic seq_le(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] diff;
      diff = b - a;
      return ~diff[SEQ_W-1];
   endfunction

   function automatic logic [SEQ_W-1:0] at_least_one(input logic [SEQ_W-1:0] v);
      return (v == '0) ? {{(SEQ_W-1){1'b0}}, 1'b1} : v;
   endfunction

endpackage

`default_nettype wire

### design/tcpcc_ifs.sv
// Channel interfaces: request, response and configuration write.
`default_nettype none

interface tcpcc_req_if;
   logic                            valid;
   logic                            ready;
   logic [tcpcc_pkg::KIND_W-1:0]    req_type;
   logic [tcpcc_pkg::SEQ_W-1:0]     seq_num;
   logic [tcpcc_pkg::SEQ_W-1:0]     ack_num;
   logic [tcpcc_pkg::WIN_W-1:0]     peer_window;
   logic [tcpcc_pkg::LEN_W-1:0]     seg_len;

   modport source (output valid, req_type, seq_num, ack_num, peer_window, seg_len,
                   input ready);
   modport sink   (input valid, req_type, seq_num, ack_num, peer_window, seg_len,
                   output ready);
endinterface

interface tcpcc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tcpcc_pkg::RES_W-1:0]     result_kind;
   logic                            retransmit_head;
   logic [tcpcc_pkg::TIMER_W-1:0]   timer_action;
   logic [tcpcc_pkg::SEQ_W-1:0]     send_window;
   logic [tcpcc_pkg::SEQ_W-1:0]     cong_window;
   logic [tcpcc_pkg::SEQ_W-1:0]     slow_start_limit;
   logic [tcpcc_pkg::SEQ_W-1:0]     bytes_in_flight;
   logic                            wake_sender;

   modport source (output valid, result_kind, retransmit_head, timer_action, send_window,
                   cong_window, slow_start_limit, bytes_in_flight, wake_sender,
                   input ready);
   modport sink   (input valid, result_kind, retransmit_head, timer_action, send_window,
                   cong_window, slow_start_limit, bytes_in_flight, wake_sender,
                   output ready);
endinterface

interface tcpcc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [tcpcc_pkg::CSR_IDX_W-1:0]   index;
   logic [tcpcc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/tcp_sender_congestion_control_core.sv
// Top level: sequencer, connection state and response register of the window control.
`default_nettype none

// Sender-side TCP Reno window control. Each request transaction (open, segment sent,
// SYN-ACK, ACK) yields exactly one response transaction carrying the result kind,
// retransmit and timer actions and the window state after the event. Requests are
// taken one at a time: open, segment-sent, SYN-ACK, duplicate, rejected and slow-start
// ACKs pass the evaluate and commit states before the response is registered; an ACK
// for new data in congestion avoidance also passes the load and divide states, where
// the single radix-2 divider produces one of the 48 quotient bits of segment_size *
// acked / cwnd per cycle. A new request is accepted while a previous response still
// waits in the output register. Configuration writes are always accepted.
module tcp_sender_congestion_control_core (
   input  logic  clock,
   input  logic  reset,
   tcpcc_csr_if.sink   csr_chan,
   tcpcc_req_if.sink   req_chan,
   tcpcc_rsp_if.source rsp_chan
);
   import tcpcc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EVAL   = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_COMMIT = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      ACT_REJECT,
      ACT_OPEN,
      ACT_SENT,
      ACT_SYNACK,
      ACT_DUP,
      ACT_HALVE,
      ACT_NEW
   } action_type;

   // Control and configuration
   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SEG_W-1:0]    seg_size_ff, seg_size_in;
   logic [THR_W-1:0]    dup_thr_ff, dup_thr_in;

   // Connection state
   logic [SEQ_W-1:0]    una_ff, una_in;
   logic [SEQ_W-1:0]    nxt_ff, nxt_in;
   logic [SEQ_W-1:0]    cwnd_ff, cwnd_in;
   logic [SEQ_W-1:0]    ssth_ff, ssth_in;
   logic [WIN_W-1:0]    peer_ff, peer_in;
   logic [SEQ_W-1:0]    eff_ff, eff_in;
   logic [THR_W-1:0]    dup_ff, dup_in;
   logic [SEQ_W-1:0]    rec_ff, rec_in;
   logic [SEQ_W-1:0]    infl_ff, infl_in;
   logic                est_ff, est_in;

   // Latched request
   logic [KIND_W-1:0]   kind_ff;
   logic [SEQ_W-1:0]    seq_ff;
   logic [SEQ_W-1:0]    ack_ff;
   logic [WIN_W-1:0]    rwnd_ff;
   logic [LEN_W-1:0]    slen_ff;

   // Evaluation results
   action_type          act_ff, act_in;
   logic [SEQ_W-1:0]    acked_ff, acked_in;
   logic                slow_ff, slow_in;
   logic [DVD_W-1:0]    prod_ff, prod_in;
   logic [THR_W-1:0]    dup_next_ff, dup_next_in;
   logic                rtx_new_ff, rtx_new_in;
   logic [TIMER_W-1:0]  tmr_new_ff, tmr_new_in;

   // Response payload
   logic [RES_W-1:0]    res_ff, res_in;
   logic                rtx_ff, rtx_in;
   logic [TIMER_W-1:0]  tmr_ff, tmr_in;
   logic                wake_ff, wake_in;

   logic                req_fire;
   logic                commit;
   logic                in_range;
   logic [THR_W-1:0]    dup_inc;

   div_stat_type        div_stat;
   logic [DVD_W-1:0]    div_quot;

   logic [DVD_W:0]      grown;
   logic [SEQ_W-1:0]    grown_sat;
   logic [SEQ_W-1:0]    halved;
   logic [SEQ_W-1:0]    new_cwnd;
   logic [SEQ_W-1:0]    rwnd_ext;
   logic [SEQ_W:0]      infl_sum;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign commit         = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_chan.ready);

   tcpcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_LOAD),
      .dividend (prod_ff),
      .divisor  (at_least_one(cwnd_ff)),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_EVAL;
         ST_EVAL:   state_in = (act_in == ACT_NEW && !slow_in) ? ST_LOAD : ST_COMMIT;
         ST_LOAD:   state_in = ST_DIV;
         ST_DIV:    if (div_stat.done) state_in = ST_COMMIT;
         ST_COMMIT: if (commit) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Configuration writes
   always_comb begin
      seg_size_in = seg_size_ff;
      dup_thr_in  = dup_thr_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         if (csr_chan.index == CSR_SEG_SIZE) begin
            seg_size_in = csr_chan.data[SEG_W-1:0];
         end else if (csr_chan.index == CSR_DUP_THRESH) begin
            dup_thr_in = csr_chan.data[THR_W-1:0];
         end
      end
   end

   // Classify the event against the current state
   assign in_range = seq_le(una_ff, ack_ff) && seq_le(ack_ff, nxt_ff);
   assign dup_inc  = dup_ff + 1'b1;

   always_comb begin
      act_in      = ACT_REJECT;
      dup_next_in = dup_inc;
      acked_in    = ack_ff - una_ff;
      slow_in     = (cwnd_ff < ssth_ff);
      prod_in     = {{(DVD_W-SEG_W){1'b0}}, seg_size_ff}
                  * {{(DVD_W-SEQ_W){1'b0}}, acked_in};
      rtx_new_in  = (ack_ff != rec_ff) && seq_le(ack_ff, rec_ff);
      tmr_new_in  = (ack_ff == nxt_ff) ? TMR_CLEAR : TMR_RESTART;
      unique case (kind_ff)
         REQ_OPEN:   act_in = ACT_OPEN;
         REQ_SENT:   act_in = ACT_SENT;
         REQ_SYNACK: if (!est_ff && in_range) act_in = ACT_SYNACK;
         REQ_ACK: begin
            if (est_ff && in_range) begin
               if (ack_ff != una_ff) begin
                  act_in = ACT_NEW;
               end else if (seq_le(rec_ff, ack_ff)) begin
                  act_in = (dup_inc >= dup_thr_ff) ? ACT_HALVE : ACT_DUP;
               end
            end
         end
         default:    act_in = ACT_REJECT;
      endcase
   end

   // Window arithmetic for the commit step
   assign rwnd_ext  = {{(SEQ_W-WIN_W){1'b0}}, rwnd_ff};
   assign grown     = {{(DVD_W-SEQ_W+1){1'b0}}, cwnd_ff}
                    + {1'b0, (slow_ff ? {{(DVD_W-SEQ_W){1'b0}}, acked_ff} : div_quot)};
   assign grown_sat = (grown[DVD_W:SEQ_W] != '0) ? '1 : grown[SEQ_W-1:0];
   assign halved    = {1'b0, cwnd_ff[SEQ_W-1:1]};
   assign new_cwnd  = at_least_one((act_ff == ACT_HALVE) ? halved : grown_sat);
   assign infl_sum  = {1'b0, infl_ff} + {{(SEQ_W-LEN_W+1){1'b0}}, slen_ff};

   always_comb begin
      una_in  = una_ff;
      nxt_in  = nxt_ff;
      cwnd_in = cwnd_ff;
      ssth_in = ssth_ff;
      peer_in = peer_ff;
      eff_in  = eff_ff;
      dup_in  = dup_ff;
      rec_in  = rec_ff;
      infl_in = infl_ff;
      est_in  = est_ff;
      res_in  = RES_REJECT;
      rtx_in  = 1'b0;
      tmr_in  = TMR_KEEP;
      wake_in = 1'b0;
      unique case (act_ff)
         ACT_REJECT: res_in = RES_REJECT;
         ACT_OPEN: begin
            una_in  = seq_ff;
            nxt_in  = seq_ff;
            est_in  = 1'b0;
            infl_in = '0;
            dup_in  = '0;
            res_in  = RES_BOOK;
         end
         ACT_SENT: begin
            nxt_in  = nxt_ff + {{(SEQ_W-LEN_W){1'b0}}, slen_ff};
            infl_in = infl_sum[SEQ_W] ? '1 : infl_sum[SEQ_W-1:0];
            res_in  = RES_BOOK;
         end
         ACT_SYNACK: begin
            peer_in = rwnd_ff;
            cwnd_in = at_least_one({{(SEQ_W-SEG_W){1'b0}}, seg_size_ff});
            ssth_in = {{(SEQ_W-WIN_W+1){1'b0}}, rwnd_ff[WIN_W-1:1]};
            dup_in  = '0;
            rec_in  = ack_ff - 1'b1;
            infl_in = '0;
            eff_in  = rwnd_ext;
            una_in  = ack_ff;
            est_in  = 1'b1;
            res_in  = RES_EST;
            tmr_in  = TMR_CLEAR;
            wake_in = 1'b1;
         end
         ACT_DUP: begin
            dup_in = dup_next_ff;
            res_in = RES_DUP;
         end
         ACT_HALVE: begin
            ssth_in = halved;
            cwnd_in = new_cwnd;
            peer_in = rwnd_ff;
            eff_in  = (rwnd_ext < new_cwnd) ? rwnd_ext : new_cwnd;
            rec_in  = nxt_ff;
            dup_in  = '0;
            res_in  = RES_FRTX;
            rtx_in  = 1'b1;
         end
         ACT_NEW: begin
            dup_in  = '0;
            infl_in = (infl_ff > acked_ff) ? infl_ff - acked_ff : '0;
            peer_in = rwnd_ff;
            cwnd_in = new_cwnd;
            eff_in  = (rwnd_ext < new_cwnd) ? rwnd_ext : new_cwnd;
            una_in  = ack_ff;
            rtx_in  = rtx_new_ff;
            tmr_in  = tmr_new_ff;
            wake_in = 1'b1;
            res_in  = RES_NEW;
         end
         default: res_in = RES_REJECT;
      endcase
   end

   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         seg_size_ff  <= SEG_SIZE_RESET;
         dup_thr_ff   <= DUP_THRESH_RESET;
         una_ff       <= '0;
         nxt_ff       <= '0;
         cwnd_ff      <= {{(SEQ_W-SEG_W){1'b0}}, SEG_SIZE_RESET};
         ssth_ff      <= '0;
         peer_ff      <= '0;
         eff_ff       <= '0;
         dup_ff       <= '0;
         rec_ff       <= '0;
         infl_ff      <= '0;
         est_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seg_size_ff  <= seg_size_in;
         dup_thr_ff   <= dup_thr_in;
         if (commit) begin
            una_ff  <= una_in;
            nxt_ff  <= nxt_in;
            cwnd_ff <= cwnd_in;
            ssth_ff <= ssth_in;
            peer_ff <= peer_in;
            eff_ff  <= eff_in;
            dup_ff  <= dup_in;
            rec_ff  <= rec_in;
            infl_ff <= infl_in;
            est_ff  <= est_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_chan.req_type;
         seq_ff  <= req_chan.seq_num;
         ack_ff  <= req_chan.ack_num;
         rwnd_ff <= req_chan.peer_window;
         slen_ff <= req_chan.seg_len;
      end
      if (state_ff == ST_EVAL) begin
         act_ff      <= act_in;
         acked_ff    <= acked_in;
         slow_ff     <= slow_in;
         prod_ff     <= prod_in;
         dup_next_ff <= dup_next_in;
         rtx_new_ff  <= rtx_new_in;
         tmr_new_ff  <= tmr_new_in;
      end
      if (commit) begin
         res_ff  <= res_in;
         rtx_ff  <= rtx_in;
         tmr_ff  <= tmr_in;
         wake_ff <= wake_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.result_kind      = res_ff;
   assign rsp_chan.retransmit_head  = rtx_ff;
   assign rsp_chan.timer_action     = tmr_ff;
   assign rsp_chan.send_window      = eff_ff;
   assign rsp_chan.cong_window      = cwnd_ff;
   assign rsp_chan.slow_start_limit = ssth_ff;
   assign rsp_chan.bytes_in_flight  = infl_ff;
   assign rsp_chan.wake_sender      = wake_ff;

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_EVAL)
      else $error("accepted request not evaluated next cycle");

   a_cwnd_nonzero: assert property (@(posedge clock) disable iff (reset)
      cwnd_ff != '0)
      else $error("congestion window reached zero");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("response raised outside commit");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");

endmodule

`default_nettype wire

### design/tcpcc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module tcpcc_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tcpcc_pkg::DVD_W-1:0]      dividend,
   input  logic [tcpcc_pkg::DSR_W-1:0]      divisor,
   output tcpcc_pkg::div_stat_type          stat,
   output logic [tcpcc_pkg::DVD_W-1:0]      quotient
);
   import tcpcc_pkg::*;

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DVD_W-1:0]    dq_ff, dq_in;
   logic [DSR_W-1:0]    rem_ff, rem_in;
   logic [DSR_W-1:0]    dsr_ff, dsr_in;

   logic [DSR_W:0]      shifted;
   logic                fits;

   assign shifted = {rem_ff, dq_ff[DVD_W-1]};
   assign fits    = (shifted >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = LAST_STEP;
         dq_in   = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = fits ? DSR_W'(shifted - {1'b0, dsr_ff}) : shifted[DSR_W-1:0];
         dq_in  = {dq_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dq_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && $past(cnt_ff) == '0)
      else $error("divider done without finishing its last step");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff && $past(busy_ff) |-> rem_ff < dsr_ff)
      else $error("partial remainder not below divisor");

endmodule

`default_nettype wire
